// ===== rtl/core/scsa_pkg.sv =====
// Shared types, constants and helpers for the size-class slab allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package scsa_pkg;

  localparam int NUM_PAGES   = 64;
  localparam int PAGE_IDX_W  = $clog2(NUM_PAGES);
  localparam int PAGE_W      = PAGE_IDX_W + 1;
  localparam int ENTRY_SLOTS = 128;
  localparam int ENTRY_IDX_W = 7;
  localparam int ENTRY_W     = ENTRY_IDX_W + 1;
  localparam int CLASS_W     = 3;
  localparam int OWNER_W     = 4;
  localparam int SLAB_CLASSES = 7;

  localparam logic [PAGE_W-1:0]  PAGE_NULL   = PAGE_W'(NUM_PAGES);
  localparam logic [ENTRY_W-1:0] ENTRY_NULL  = ENTRY_W'(ENTRY_SLOTS);
  localparam logic [CLASS_W-1:0] WHOLE_CLASS = 3'd7;
  localparam logic [OWNER_W-1:0] OWNER_WHOLE = 4'd8;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SIZE  = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_WALK, S_WALK_CHK, S_POP_RD, S_POP, S_SCAN,
    S_CHAIN, S_TAKE, S_FREE_RD, S_FREE_CHK, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    PS_HOLD, PS_CLASS_HEAD, PS_FREE_ADDR, PS_LINK, PS_ZERO, PS_INC
  } page_sel_t;

  typedef enum logic [1:0] {
    ES_HOLD, ES_FH, ES_ONE, ES_INC
  } entry_sel_t;

  typedef struct packed {
    logic       load_in;
    page_sel_t  page_sel;
    entry_sel_t entry_sel;
    logic       guard_inc;
    logic       take_whole;
    logic       take_slab;
    logic       chain_wr;
    logic       pop_wr;
    logic       free_whole;
    logic       free_slab;
    logic       set_status;
    status_t    status_code;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic bad_size;
    logic is_free;
    logic is_whole;
    logic free_oob;
    logic page_null;
    logic guard_over;
    logic fh_empty;
    logic scan_end;
    logic page_used;
    logic owner_match;
    logic chain_last;
  } sts_t;

  // Class 0..6 are slabs of 32 << c bytes, class 7 is a whole page.
  function automatic logic [CLASS_W-1:0] size_class(input logic [15:0] size);
    logic [CLASS_W-1:0] c;
    c = WHOLE_CLASS;
    if      (size <= 16'd32)   c = 3'd0;
    else if (size <= 16'd64)   c = 3'd1;
    else if (size <= 16'd128)  c = 3'd2;
    else if (size <= 16'd256)  c = 3'd3;
    else if (size <= 16'd512)  c = 3'd4;
    else if (size <= 16'd1024) c = 3'd5;
    else if (size <= 16'd2048) c = 3'd6;
    return c;
  endfunction

endpackage

// ===== rtl/core/scsa_ctrl.sv =====
// Controller state machine for the slab allocator.
// Depends on scsa_pkg; drives the datapath through cmd_t and reads sts_t.
module scsa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output scsa_pkg::cmd_t cmd,
  input  scsa_pkg::sts_t sts
);
  import scsa_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (sts.bad_size) state_next = S_DONE;
        else if (sts.is_free) state_next = sts.free_oob ? S_DONE : S_FREE_RD;
        else if (sts.is_whole) state_next = S_SCAN;
        else state_next = S_WALK;
      end
      S_WALK:     state_next = (sts.page_null || sts.guard_over) ? S_SCAN : S_WALK_CHK;
      S_WALK_CHK: state_next = sts.fh_empty ? S_WALK : S_POP_RD;
      S_POP_RD:   state_next = S_POP;
      S_POP:      state_next = S_DONE;
      S_SCAN: begin
        if (sts.scan_end) state_next = S_DONE;
        else if (!sts.page_used) state_next = sts.is_whole ? S_DONE : S_CHAIN;
      end
      S_CHAIN:    if (sts.chain_last) state_next = S_TAKE;
      S_TAKE:     state_next = S_DONE;
      S_FREE_RD:  state_next = S_FREE_CHK;
      S_FREE_CHK: state_next = S_DONE;
      S_DONE:     if (!out_valid || out_ready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.page_sel   = PS_HOLD;
    cmd.entry_sel  = ES_HOLD;
    cmd.status_code = ST_OK;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_DECODE: begin
        if (sts.bad_size) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_BAD_SIZE;
        end else if (sts.is_free) begin
          if (sts.free_oob) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_NOT_FOUND;
          end else begin
            cmd.page_sel = PS_FREE_ADDR;
          end
        end else if (sts.is_whole) begin
          cmd.page_sel = PS_ZERO;
        end else begin
          cmd.page_sel = PS_CLASS_HEAD;
        end
      end
      S_WALK: begin
        if (sts.page_null || sts.guard_over) cmd.page_sel = PS_ZERO;
      end
      S_WALK_CHK: begin
        if (sts.fh_empty) begin
          cmd.page_sel  = PS_LINK;
          cmd.guard_inc = 1'b1;
        end else begin
          cmd.entry_sel = ES_FH;
        end
      end
      S_POP_RD: ;
      S_POP:    cmd.pop_wr = 1'b1;
      S_SCAN: begin
        if (sts.scan_end) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_EXHAUSTED;
        end else if (sts.page_used) begin
          cmd.page_sel = PS_INC;
        end else if (sts.is_whole) begin
          cmd.take_whole = 1'b1;
        end else begin
          cmd.entry_sel = ES_ONE;
        end
      end
      S_CHAIN: begin
        cmd.chain_wr  = 1'b1;
        cmd.entry_sel = ES_INC;
      end
      S_TAKE:    cmd.take_slab = 1'b1;
      S_FREE_RD: ;
      S_FREE_CHK: begin
        if (!sts.owner_match) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_NOT_FOUND;
        end else if (sts.is_whole) begin
          cmd.free_whole = 1'b1;
        end else begin
          cmd.free_slab = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/scsa_datapath.sv =====
// Datapath of the slab allocator: page, list and entry stores, scan and
// address arithmetic, configuration and result registers. Depends on scsa_pkg.
module scsa_datapath (
  input  logic           clk,
  input  logic           rst,
  input  scsa_pkg::cmd_t cmd,
  output scsa_pkg::sts_t sts,
  input  logic           command,
  input  logic [15:0]    size,
  input  logic [31:0]    address,
  input  logic           cfg_write,
  input  logic           cfg_index,
  input  logic [19:0]    cfg_data,
  output logic [31:0]    address_out,
  output logic [1:0]     status
);
  import scsa_pkg::*;

  logic [19:0] pool_base_page;
  logic [6:0]  pool_page_count;

  logic        req_cmd;
  logic [15:0] req_size;
  logic [31:0] req_addr;

  logic [PAGE_W-1:0]      page;
  logic [ENTRY_IDX_W-1:0] entry;
  logic [PAGE_W-1:0]      guard;

  logic [NUM_PAGES-1:0]   page_used;
  logic [PAGE_W-1:0]      class_head [SLAB_CLASSES];

  logic [OWNER_W-1:0] owner_mem [NUM_PAGES];
  logic [PAGE_W-1:0]  link_mem  [NUM_PAGES];
  logic [ENTRY_W-1:0] fh_mem    [NUM_PAGES];
  logic [ENTRY_W-1:0] el_mem    [NUM_PAGES*ENTRY_SLOTS];

  logic [OWNER_W-1:0] owner_rd;
  logic [PAGE_W-1:0]  link_rd;
  logic [ENTRY_W-1:0] fh_rd;
  logic [ENTRY_W-1:0] el_rd;

  logic [31:0] res_addr;
  status_t     res_status;

  logic [CLASS_W-1:0]     cls;
  logic [PAGE_IDX_W-1:0]  pidx;
  logic [19:0]            free_diff;
  logic [ENTRY_IDX_W-1:0] free_entry;
  logic [ENTRY_W-1:0]     slots;
  logic [ENTRY_W-1:0]     entry_inc;
  logic [17:0]            off_wide;
  logic [19:0]            ppn;
  logic [PAGE_IDX_W+ENTRY_IDX_W-1:0] el_addr;
  logic [PAGE_IDX_W+ENTRY_IDX_W-1:0] el_free_addr;

  assign cls          = size_class(req_size);
  assign pidx         = page[PAGE_IDX_W-1:0];
  assign free_diff    = req_addr[31:12] - pool_base_page;
  assign free_entry   = ENTRY_IDX_W'(req_addr[11:0] >> (4'd5 + {1'b0, cls}));
  assign slots        = ENTRY_W'(ENTRY_SLOTS) >> cls;
  assign entry_inc    = {1'b0, entry} + 1'b1;
  assign off_wide     = {11'd0, entry} << (4'd5 + {1'b0, cls});
  assign ppn          = pool_base_page + {{(20-PAGE_IDX_W){1'b0}}, pidx};
  assign el_addr      = {pidx, entry};
  assign el_free_addr = {pidx, free_entry};

  always_comb begin
    sts.bad_size    = (req_size == 16'd0) || (req_size > 16'd4096);
    sts.is_free     = req_cmd;
    sts.is_whole    = (cls == WHOLE_CLASS);
    sts.free_oob    = (free_diff[19:PAGE_IDX_W] != '0);
    sts.page_null   = (page >= PAGE_NULL);
    sts.guard_over  = (guard >= PAGE_W'(NUM_PAGES));
    sts.fh_empty    = (fh_rd >= ENTRY_NULL);
    sts.scan_end    = (page >= PAGE_NULL) || ({1'b0, page} >= {1'b0, pool_page_count});
    sts.page_used   = page_used[pidx];
    sts.owner_match = page_used[pidx] &&
                      (owner_rd == (sts.is_whole ? OWNER_WHOLE : {1'b0, cls} + 1'b1));
    sts.chain_last  = (entry_inc >= slots);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base_page  <= '0;
      pool_page_count <= 7'd64;
    end else if (cfg_write) begin
      if (cfg_index) pool_page_count <= cfg_data[6:0];
      else           pool_base_page  <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_cmd  <= command;
      req_size <= size;
      req_addr <= address;
    end
    unique case (cmd.page_sel)
      PS_HOLD:       page <= page;
      PS_CLASS_HEAD: page <= class_head[cls];
      PS_FREE_ADDR:  page <= {1'b0, free_diff[PAGE_IDX_W-1:0]};
      PS_LINK:       page <= link_rd;
      PS_ZERO:       page <= '0;
      PS_INC:        page <= page + 1'b1;
      default:       page <= page;
    endcase
    if (cmd.page_sel == PS_CLASS_HEAD) guard <= '0;
    else if (cmd.guard_inc)            guard <= guard + 1'b1;
    unique case (cmd.entry_sel)
      ES_HOLD: entry <= entry;
      ES_FH:   entry <= fh_rd[ENTRY_IDX_W-1:0];
      ES_ONE:  entry <= ENTRY_IDX_W'(1);
      ES_INC:  entry <= entry_inc[ENTRY_IDX_W-1:0];
      default: entry <= entry;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_used <= '0;
      for (int i = 0; i < SLAB_CLASSES; i++) class_head[i] <= PAGE_NULL;
    end else begin
      if (cmd.take_whole || cmd.take_slab) page_used[pidx] <= 1'b1;
      if (cmd.free_whole)                  page_used[pidx] <= 1'b0;
      if (cmd.take_slab)                   class_head[cls] <= page;
    end
  end

  always_ff @(posedge clk) begin
    owner_rd <= owner_mem[pidx];
    link_rd  <= link_mem[pidx];
    fh_rd    <= fh_mem[pidx];
    el_rd    <= el_mem[el_addr];
    if (cmd.take_whole) owner_mem[pidx] <= OWNER_WHOLE;
    if (cmd.take_slab) begin
      owner_mem[pidx] <= {1'b0, cls} + 1'b1;
      link_mem[pidx]  <= class_head[cls];
    end
    if (cmd.take_slab)      fh_mem[pidx] <= ENTRY_W'(1);
    else if (cmd.pop_wr)    fh_mem[pidx] <= el_rd;
    else if (cmd.free_slab) fh_mem[pidx] <= {1'b0, free_entry};
    if (cmd.chain_wr)
      el_mem[el_addr] <= sts.chain_last ? ENTRY_NULL : entry_inc;
    else if (cmd.free_slab)
      el_mem[el_free_addr] <= fh_rd;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      res_addr   <= '0;
      res_status <= ST_OK;
    end else if (cmd.set_status) begin
      res_status <= cmd.status_code;
    end else if (cmd.take_whole || cmd.take_slab) begin
      res_addr <= {ppn, 12'd0};
    end else if (cmd.pop_wr) begin
      res_addr <= {ppn, off_wide[11:0]};
    end
    if (cmd.out_load) begin
      address_out <= res_addr;
      status      <= res_status;
    end
  end

endmodule

// ===== rtl/core/size_class_slab_allocator_unit.sv =====
// Top level of the size-class slab allocator.
// Joins scsa_ctrl and scsa_datapath; depends on scsa_pkg.
//
// Requests arrive on the in channel (command, size, address) and each gives
// exactly one word on the out channel (address_out, status); both channels
// use valid and ready. The configuration port writes pool_base_page (index 0)
// and pool_page_count (index 1) with cfg_write, taking effect at once; the
// user must write it only while the block is idle, which is not enforced.
// One request is handled at a time. A bad size, or a free address outside
// the pool, goes from decode straight to the result step. A whole-page
// allocate or a new slab page scans the pool one page a cycle, and a new
// slab page then chains its entries one a cycle. A slab allocate walks its
// class page list page by page; any other free reads, then checks, the owner.
// The result sits in an output register, so the next request is taken while
// it waits; a stalled receiver holds the block in its final step until the
// output register is free. Synchronous reset empties the pool and all class
// lists and restores the configuration defaults; no clearing pass is needed.
module size_class_slab_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [15:0] size,
  input  logic [31:0] address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] address_out,
  output logic [1:0]  status,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data
);
  import scsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  scsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  scsa_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .command     (command),
    .size        (size),
    .address     (address),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .address_out (address_out),
    .status      (status)
  );

endmodule

// ===== rtl/core/scsa_checker.sv =====
// Port-level checks for the slab allocator top level, with its bind.
// Depends on size_class_slab_allocator_unit.
module scsa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] address_out,
  input logic [1:0]  status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(address_out) && $stable(status))
    else $error("Result word changed while stalled.");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != 2'd0 |-> address_out == 32'd0)
    else $error("Error result carries a nonzero address.");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("Result valid directly after reset.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Second request taken while one is in progress.");

endmodule

bind size_class_slab_allocator_unit scsa_checker u_scsa_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .address_out (address_out),
  .status      (status)
);

// ===== tb/tb_size_class_slab_allocator_unit.sv =====
// Testbench for the size-class slab allocator: random alloc and free traffic with
// a scoreboard that predicts every result word from its own copy of the pool state.
// Depends on scsa_pkg and size_class_slab_allocator_unit.
`timescale 1ns / 100ps

import scsa_pkg::*;

typedef struct {
  logic [31:0] addr;
  status_t     st;
} result_t;

class slab_scoreboard;
  bit [19:0] base_page;
  bit [6:0]  page_count;
  bit [3:0]  owner [64];
  bit [6:0]  plink [64];
  bit [6:0]  head [7];
  bit [7:0]  fhead [64];
  bit [7:0]  elink [8192];
  result_t   pending [$];
  int        errors;
  int        mismatches;

  function new();
    base_page  = 0;
    page_count = 64;
    foreach (owner[i]) owner[i] = 0;
    foreach (head[i]) head[i] = 7'd64;
    errors     = 0;
    mismatches = 0;
  endfunction

  function int class_of(bit [15:0] sz);
    if (sz == 0 || sz > 4096) return -1;
    for (int c = 0; c < 8; c++)
      if (sz <= (32 << c)) return c;
    return -1;
  endfunction

  function int lowest_free_page();
    int lim;
    lim = (page_count > 64) ? 64 : page_count;
    for (int p = 0; p < lim; p++)
      if (owner[p] == 0) return p;
    return 64;
  endfunction

  function bit [31:0] page_addr(int p, int off);
    bit [19:0] ppn;
    ppn = base_page + 20'(p);
    return {ppn, 12'h000} + 32'(off);
  endfunction

  function result_t note_request(bit cmd, bit [15:0] sz, bit [31:0] address);
    result_t r;
    int c, p, guard, n, e, shift;
    r.addr = 0;
    r.st   = ST_OK;
    c = class_of(sz);
    if (c < 0) begin
      r.st = ST_BAD_SIZE;
    end else if (cmd == 1'b0) begin
      if (c == 7) begin
        p = lowest_free_page();
        if (p == 64) begin
          r.st = ST_EXHAUSTED;
        end else begin
          owner[p] = 4'd8;
          r.addr = page_addr(p, 0);
        end
      end else begin
        shift = 5 + c;
        p = head[c];
        guard = 0;
        while (p < 64 && guard < 64 && fhead[p] >= 128) begin
          p = plink[p];
          guard++;
        end
        if (p >= 64 || guard >= 64) begin
          p = lowest_free_page();
          if (p == 64) begin
            r.st = ST_EXHAUSTED;
          end else begin
            n = 4096 >> shift;
            for (e = 0; e < n; e++)
              elink[p * 128 + e] = 8'((e + 1 < n) ? e + 1 : 128);
            fhead[p] = 0;
            owner[p] = 4'(c + 1);
            plink[p] = head[c];
            head[c] = 7'(p);
          end
        end
        if (r.st == ST_OK) begin
          e = fhead[p];
          fhead[p] = elink[p * 128 + e];
          r.addr = page_addr(p, e << shift);
        end
      end
    end else begin
      p = int'(((address >> 12) - 32'(base_page)) & 32'hFFFFF);
      if (p >= 64) begin
        r.st = ST_NOT_FOUND;
      end else if (c == 7) begin
        if (owner[p] == 4'd8) owner[p] = 0;
        else r.st = ST_NOT_FOUND;
      end else if (owner[p] != c + 1) begin
        r.st = ST_NOT_FOUND;
      end else begin
        shift = 5 + c;
        e = int'((address & 32'hFFF) >> shift);
        elink[p * 128 + e] = fhead[p];
        fhead[p] = 8'(e);
      end
    end
    pending.push_back(r);
    return r;
  endfunction

  function void check_result(logic [31:0] a, logic [1:0] s);
    result_t r;
    if (pending.size() == 0) begin
      errors++;
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected word: address_out %h status %0d", a, s);
      return;
    end
    r = pending.pop_front();
    if (a !== r.addr || s !== r.st) begin
      errors++;
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch: expected address_out %h status %0d, got %h status %0d",
                 r.addr, r.st, a, s);
    end
  endfunction
endclass

module tb_size_class_slab_allocator_unit;
  localparam bit CMD_ALLOC = 1'b0;
  localparam bit CMD_FREE  = 1'b1;
  localparam bit REG_POOL_BASE  = 1'b0;
  localparam bit REG_POOL_COUNT = 1'b1;
  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    int pg;
    int off;
    int cls;
  } block_t;

  logic        clk = 0;
  logic        rst;
  logic        in_valid, in_ready, command;
  logic [15:0] size;
  logic [31:0] address;
  logic        out_valid, out_ready;
  logic [31:0] address_out;
  logic [1:0]  status;
  logic        cfg_write, cfg_index;
  logic [19:0] cfg_data;

  slab_scoreboard sb;
  block_t live [$];
  int     hold_cycles = 0;
  int     idle_count = 0;
  int     burst_left = 0;

  size_class_slab_allocator_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .size(size), .address(address),
    .out_valid(out_valid), .out_ready(out_ready),
    .address_out(address_out), .status(status),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(address_out, status);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: a long hold-off when asked, otherwise a changing stall pattern.
  initial begin
    int mode;
    mode = 0;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 0;
        hold_cycles--;
      end else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_ready = 1;
          1: out_ready = 1'($urandom_range(0, 1));
          2: out_ready = ($urandom_range(0, 9) != 0);
          default: out_ready = ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  task automatic send(bit cmd, bit [15:0] sz, bit [31:0] addr);
    result_t r;
    block_t b;
    int c;
    @(negedge clk);
    in_valid = 1;
    command  = cmd;
    size     = sz;
    address  = addr;
    do @(posedge clk); while (!in_ready);
    r = sb.note_request(cmd, sz, addr);
    c = sb.class_of(sz);
    if (cmd == CMD_ALLOC && r.st == ST_OK) begin
      b.pg  = int'(((r.addr >> 12) - 32'(sb.base_page)) & 32'hFFFFF);
      b.off = int'(r.addr & 32'hFFF);
      b.cls = c;
      live.push_back(b);
    end
  endtask

  task automatic pause_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 20);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
    @(negedge clk);
    in_valid = 0;
    repeat (gap) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  task automatic write_reg(bit idx, bit [19:0] val);
    @(negedge clk);
    cfg_write = 1;
    cfg_index = idx;
    cfg_data  = val;
    if (idx == REG_POOL_BASE) sb.base_page = val;
    else sb.page_count = val[6:0];
    @(negedge clk);
    cfg_write = 0;
  endtask

  function automatic bit [15:0] size_of_class(int c);
    int lo, hi;
    lo = (c == 0) ? 1 : (16 << c) + 1;
    hi = 32 << c;
    case ($urandom_range(0, 5))
      0: return 16'(lo);
      1: return 16'(hi);
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic bit [31:0] live_addr(block_t b);
    bit [19:0] ppn;
    ppn = sb.base_page + 20'(b.pg);
    return {ppn, 12'h000} + 32'(b.off);
  endfunction

  task automatic free_live(bit unaligned, bit keep);
    block_t b;
    int k;
    bit [31:0] a;
    k = $urandom_range(0, live.size() - 1);
    b = live[k];
    a = live_addr(b);
    if (unaligned && b.cls < 7) a = a + 32'($urandom_range(0, (32 << b.cls) - 1));
    if (!keep) live.delete(k);
    send(CMD_FREE, size_of_class(b.cls), a);
  endtask

  task automatic random_item();
    int r, c;
    r = $urandom_range(0, 99);
    if (live.size() > 120 && r < 50) r = r + 50;
    if (r < 50 || (r < 85 && live.size() == 0)) begin
      c = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 6);
      send(CMD_ALLOC, size_of_class(c), $urandom);
    end else if (r < 85) begin
      free_live($urandom_range(0, 3) == 0, 0);
    end else begin
      case ($urandom_range(0, 4))
        0: send(1'($urandom_range(0, 1)), 16'($urandom_range(4097, 65535)), $urandom);
        1: send(1'($urandom_range(0, 1)), 16'd0, $urandom);
        2: send(CMD_FREE, size_of_class($urandom_range(0, 7)), $urandom);
        3: if (live.size() > 0) begin
          c = live[0].cls;
          send(CMD_FREE, size_of_class((c + $urandom_range(1, 7)) % 8), live_addr(live[0]));
        end else begin
          send(CMD_FREE, 16'd4096, 32'hFFFFFFFF);
        end
        default: if (live.size() > 0) free_live(0, 1);
          else send(CMD_ALLOC, 16'd1, 32'hFFFFFFFF);
      endcase
    end
    pause_sender();
  endtask

  task automatic random_run(int n);
    repeat (n) random_item();
  endtask

  initial begin
    sb = new();
    rst = 1;
    in_valid = 0;
    command = 0;
    size = 0;
    address = 0;
    cfg_write = 0;
    cfg_index = 0;
    cfg_data = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send(CMD_ALLOC, 16'd0, 32'h0);
    send(CMD_ALLOC, 16'd4097, 32'hFFFFFFFF);
    send(CMD_FREE, 16'hFFFF, 32'h0);
    send(CMD_ALLOC, 16'd1, 32'h0);
    send(CMD_ALLOC, 16'd32, 32'h0);
    send(CMD_ALLOC, 16'd33, 32'h0);
    send(CMD_ALLOC, 16'd2048, 32'h0);
    send(CMD_ALLOC, 16'd2049, 32'h0);
    send(CMD_ALLOC, 16'd4096, 32'h0);
    send(CMD_FREE, 16'd4096, 32'h0000_4000);
    send(CMD_FREE, 16'd4096, 32'h0000_4000);
    send(CMD_FREE, 16'd20, 32'h0000_001F);
    send(CMD_FREE, 16'd20, 32'h0000_001F);
    send(CMD_FREE, 16'd64, 32'h0000_0000);
    send(CMD_FREE, 16'd64, 32'hFFFFFFFF);
    send(CMD_ALLOC, 16'd16, 32'h0);
    send(CMD_ALLOC, 16'd16, 32'h0);
    send(CMD_ALLOC, 16'd16, 32'h0);
    random_run(480);

    drain();
    write_reg(REG_POOL_BASE, 20'hFFFFF);
    write_reg(REG_POOL_COUNT, 20'd1);
    random_run(150);

    drain();
    write_reg(REG_POOL_COUNT, 20'd0);
    random_run(40);

    drain();
    write_reg(REG_POOL_BASE, 20'($urandom));
    write_reg(REG_POOL_COUNT, 20'd127);
    random_run(250);
    hold_cycles = 400;
    random_run(150);

    drain();
    write_reg(REG_POOL_BASE, 20'd0);
    write_reg(REG_POOL_COUNT, 20'd2);
    random_run(150);

    drain();
    write_reg(REG_POOL_COUNT, 20'd64);
    random_run(150);

    drain();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/scsa_pkg.sv
rtl/core/scsa_ctrl.sv
rtl/core/scsa_datapath.sv
rtl/core/size_class_slab_allocator_unit.sv
rtl/core/scsa_checker.sv
tb/tb_size_class_slab_allocator_unit.sv
